// ===== src/wbs_pkg.sv =====
// ----------------------------------------------------------------------------
// wbs_pkg
// shared types, constants and helper functions of the window blur/sharpen
// filter
// ----------------------------------------------------------------------------
package wbs_pkg;

  localparam int WBS_MAX_WIDTH   = 1024;
  localparam int WBS_MAX_RADIUS  = 2;
  localparam int WBS_WEIGHT_FRAC = 16;
  localparam int HEIGHT_LIMIT    = 4096;
  localparam int HW              = 13;   // effective height width
  localparam int ROW_W           = 12;   // row position width
  localparam int PIX_MAX         = 255;
  localparam int RECIP_SHIFT     = 20;
  localparam int RECIP_W         = 17;
  localparam int AMT_W           = 12;
  localparam int WGT_W           = 16;
  localparam int ADDR_W          = 6;
  localparam int DATA_W          = 64;

  typedef enum logic [1:0] {
    MODE_MEAN    = 2'd0,
    MODE_GAUSS   = 2'd1,
    MODE_SHARPEN = 2'd2,
    MODE_RSVD    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_RADIUS  = 3'd1,
    REG_WIDTH   = 3'd2,
    REG_HEIGHT  = 3'd3,
    REG_W_NEAR  = 3'd4,
    REG_W_FAR   = 3'd5,
    REG_AMOUNT  = 3'd6,
    REG_NONE    = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SWEEP,
    ST_DRAIN,
    ST_POST1,
    ST_POST2,
    ST_EMIT
  } state_t;

  // one window tap travelling alongside its memory read
  typedef struct packed {
    logic             vld;
    logic             inb;
    logic             centre;
    logic [WGT_W-1:0] weight;
  } tap_t;

  // sequencing strobes for the accumulator
  typedef struct packed {
    logic clear;
    logic post1;
    logic post2;
  } acc_ctl_t;

  // weight by squared distance, from the absolute row and column offsets
  function automatic logic [WGT_W-1:0] weight_sel(input logic [1:0] a,
                                                  input logic [1:0] b,
                                                  input logic [47:0] wn,
                                                  input logic [47:0] wf);
    logic [1:0] lo;
    logic [1:0] hi;
    logic [WGT_W-1:0] w;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    case ({lo, hi})
      4'b0000: w = wn[15:0];
      4'b0001: w = wn[31:16];
      4'b0101: w = wn[47:32];
      4'b0010: w = wf[15:0];
      4'b0110: w = wf[31:16];
      4'b1010: w = wf[47:32];
      default: w = '0;
    endcase
    return w;
  endfunction

  // ceil(2^20 / side^2): floor division of a window sum by the area
  function automatic logic [RECIP_W-1:0] mean_recip(input logic [1:0] rad);
    logic [RECIP_W-1:0] m;
    case (rad)
      2'd1:    m = RECIP_W'(116509);
      2'd2:    m = RECIP_W'(41944);
      2'd3:    m = RECIP_W'(21400);
      default: m = RECIP_W'(116509);
    endcase
    return m;
  endfunction

endpackage

// ===== src/window_blur_sharpen_filter.sv =====
// ----------------------------------------------------------------------------
// window_blur_sharpen_filter
// streaming 3x3 / 5x5 mean, gaussian and unsharp filter over line stores
// ----------------------------------------------------------------------------
// Pixels enter in raster order; the last 2*MAX_RADIUS+1 rows live in one
// single-port line store, and each output pixel is formed by reading its
// window back from that store one tap per clock. No new input is taken
// while the single read port of the line store walks the window. Out-of-image
// neighbours read as zero. A flush transaction carries no pixel and only
// releases pending outputs at the bottom of a frame. A finished result waits
// in an output register, so the next input transaction is taken while it is
// pending. Register map (64-bit data, byte address 8*i): mode, radius,
// width, height, weights_near, weights_far, sharpen_amount.
module window_blur_sharpen_filter #(
  parameter int MAX_WIDTH        = wbs_pkg::WBS_MAX_WIDTH,
  parameter int MAX_RADIUS       = wbs_pkg::WBS_MAX_RADIUS,
  parameter int WEIGHT_FRAC_BITS = wbs_pkg::WBS_WEIGHT_FRAC
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // pixel input
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_pixel_value,
  input  logic                       in_flush,
  // filtered output
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_pixel,
  output logic                       out_frame_last,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wbs_pkg::ADDR_W-1:0] paddr,
  input  logic [wbs_pkg::DATA_W-1:0] pwdata,
  output logic [wbs_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import wbs_pkg::*;

  localparam int STORE_ROWS = 2 * MAX_RADIUS + 1;
  localparam int SW         = $clog2(STORE_ROWS);
  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int DW         = $clog2(MAX_RADIUS + 1) + 1;

  // configuration registers
  logic [1:0]       cfg_mode_r;
  logic [1:0]       cfg_radius_r;
  logic [10:0]      cfg_width_r;
  logic [12:0]      cfg_height_r;
  logic [47:0]      cfg_wnear_r;
  logic [47:0]      cfg_wfar_r;
  logic [AMT_W-1:0] cfg_amount_r;
  reg_idx_t         cfg_idx;

  // effective sizes
  logic [CW:0]      eff_w;
  logic [HW-1:0]    eff_h;
  logic [1:0]       eff_r;

  // positions
  logic [ROW_W-1:0] in_row_r, out_row_r;
  logic [CW-1:0]    in_col_r, out_col_r;
  logic [SW-1:0]    in_slot_r, out_slot_r;
  logic             in_ahead_r;

  state_t           state_r, state_nxt;
  logic signed [DW-1:0] dr_r, dc_r, rad_s;
  logic             drain_r;

  logic             accept, mem_we, issue, emit, ready_chk, last_tap;
  acc_ctl_t         ctl;
  tap_t             tap, tap_r;
  logic [SW+CW-1:0] mem_addr;
  logic [7:0]       rdata, result;
  logic             out_valid_r, out_last_r;
  logic [7:0]       out_pixel_r;

  // ---- configuration port ----
  assign cfg_idx = reg_idx_t'(paddr[5:3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r   <= MODE_MEAN;
      cfg_radius_r <= 2'd1;
      cfg_width_r  <= 11'd1024;
      cfg_height_r <= 13'd1024;
      cfg_wnear_r  <= '0;
      cfg_wfar_r   <= '0;
      cfg_amount_r <= AMT_W'(256);
    end else if (psel && penable && pwrite && pready) begin
      case (cfg_idx)
        REG_MODE:   cfg_mode_r   <= pwdata[1:0];
        REG_RADIUS: cfg_radius_r <= pwdata[1:0];
        REG_WIDTH:  cfg_width_r  <= pwdata[10:0];
        REG_HEIGHT: cfg_height_r <= pwdata[12:0];
        REG_W_NEAR: cfg_wnear_r  <= pwdata[47:0];
        REG_W_FAR:  cfg_wfar_r   <= pwdata[47:0];
        REG_AMOUNT: cfg_amount_r <= pwdata[AMT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MODE:   prdata = DATA_W'(cfg_mode_r);
      REG_RADIUS: prdata = DATA_W'(cfg_radius_r);
      REG_WIDTH:  prdata = DATA_W'(cfg_width_r);
      REG_HEIGHT: prdata = DATA_W'(cfg_height_r);
      REG_W_NEAR: prdata = DATA_W'(cfg_wnear_r);
      REG_W_FAR:  prdata = DATA_W'(cfg_wfar_r);
      REG_AMOUNT: prdata = DATA_W'(cfg_amount_r);
      default:    prdata = '0;
    endcase
  end

  // saturate sizes and radius to what the hardware holds; zero becomes one
  always_comb begin
    if (cfg_width_r == 11'd0) begin
      eff_w = (CW+1)'(1);
    end else if (int'(cfg_width_r) > MAX_WIDTH) begin
      eff_w = (CW+1)'(MAX_WIDTH);
    end else begin
      eff_w = (CW+1)'(cfg_width_r);
    end
    if (cfg_height_r == 13'd0) begin
      eff_h = HW'(1);
    end else if (int'(cfg_height_r) > HEIGHT_LIMIT) begin
      eff_h = HW'(HEIGHT_LIMIT);
    end else begin
      eff_h = cfg_height_r;
    end
    if (cfg_radius_r == 2'd0) begin
      eff_r = 2'd1;
    end else if (int'(cfg_radius_r) > MAX_RADIUS) begin
      eff_r = 2'(MAX_RADIUS);
    end else begin
      eff_r = cfg_radius_r;
    end
  end

  assign rad_s = DW'(eff_r);

  // ---- output readiness: input has passed the window's last pixel ----
  logic [HW-1:0] rr;
  logic [CW+2:0] cc;
  always_comb begin
    rr = HW'(out_row_r) + HW'(eff_r);
    if (rr > eff_h - HW'(1)) begin
      rr = eff_h - HW'(1);
    end
    cc = (CW+3)'(out_col_r) + (CW+3)'(eff_r);
    if (cc > (CW+3)'(eff_w) - (CW+3)'(1)) begin
      cc = (CW+3)'(eff_w) - (CW+3)'(1);
    end
    ready_chk = in_ahead_r || (HW'(in_row_r) > rr) ||
                ((HW'(in_row_r) == rr) && ((CW+3)'(in_col_r) > cc));
  end

  // ---- state machine ----
  assign last_tap = (dr_r == rad_s) && (dc_r == rad_s);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = ready_chk ? ST_SWEEP : ST_IDLE;
      ST_SWEEP: if (last_tap) state_nxt = ST_DRAIN;
      ST_DRAIN: if (drain_r) state_nxt = ST_POST1;
      ST_POST1: state_nxt = ST_POST2;
      ST_POST2: state_nxt = ST_EMIT;
      ST_EMIT:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    ctl.clear = (state_r == ST_CHECK);
    ctl.post1 = (state_r == ST_POST1);
    ctl.post2 = (state_r == ST_POST2);
    issue     = (state_r == ST_SWEEP);
    emit      = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  end

  assign accept = in_valid && in_ready;
  assign mem_we = accept && !in_flush;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // window walk, row-major over dr then dc
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dr_r    <= '0;
      dc_r    <= '0;
      drain_r <= 1'b0;
    end else if (state_r == ST_CHECK) begin
      dr_r    <= -rad_s;
      dc_r    <= -rad_s;
      drain_r <= 1'b0;
    end else if (issue) begin
      if (dc_r == rad_s) begin
        dc_r <= -rad_s;
        dr_r <= dr_r + DW'(1);
      end else begin
        dc_r <= dc_r + DW'(1);
      end
    end else if (state_r == ST_DRAIN) begin
      drain_r <= 1'b1;
    end
  end

  // tap address, bounds and weight
  logic signed [HW:0]   r_abs;
  logic signed [CW+2:0] c_abs;
  logic signed [SW+1:0] slot_s;
  logic [SW-1:0]        rd_slot;
  logic [DW-1:0]        adr, adc;
  always_comb begin
    r_abs  = $signed((HW+1)'(out_row_r)) + (HW+1)'(dr_r);
    c_abs  = $signed((CW+3)'(out_col_r)) + (CW+3)'(dc_r);
    slot_s = $signed((SW+2)'(out_slot_r)) + (SW+2)'(dr_r);
    if (slot_s < 0) begin
      slot_s = slot_s + (SW+2)'(STORE_ROWS);
    end else if (slot_s >= (SW+2)'(STORE_ROWS)) begin
      slot_s = slot_s - (SW+2)'(STORE_ROWS);
    end
    rd_slot = slot_s[SW-1:0];
    adr = dr_r[DW-1] ? DW'(-dr_r) : dr_r;
    adc = dc_r[DW-1] ? DW'(-dc_r) : dc_r;
    tap.vld    = issue;
    tap.inb    = (r_abs >= 0) && (r_abs < $signed((HW+1)'(eff_h))) &&
                 (c_abs >= 0) && (c_abs < $signed((CW+3)'(eff_w)));
    tap.centre = (dr_r == '0) && (dc_r == '0);
    tap.weight = weight_sel(2'(adr), 2'(adc), cfg_wnear_r, cfg_wfar_r);
  end

  assign mem_addr = issue ? {rd_slot, c_abs[CW-1:0]} : {in_slot_r, in_col_r};

  // tap info lines up with the registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= '0;
    end else begin
      tap_r <= tap;
    end
  end

  wbs_line_mem #(.AW(SW + CW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_pixel_value),
    .rdata (rdata)
  );

  wbs_accum #(
    .MAX_RADIUS       (MAX_RADIUS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_acc (
    .clk    (clk),
    .ctl    (ctl),
    .tap    (tap_r),
    .rdata  (rdata),
    .mode   (cfg_mode_r),
    .rad    (eff_r),
    .amount (cfg_amount_r),
    .result (result)
  );

  // ---- raster positions ----
  logic in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap;
  assign in_col_wrap  = ((CW+1)'(in_col_r) + (CW+1)'(1)) >= eff_w;
  assign in_row_wrap  = (HW'(in_row_r) + HW'(1)) >= eff_h;
  assign out_col_wrap = ((CW+1)'(out_col_r) + (CW+1)'(1)) >= eff_w;
  assign out_row_wrap = (HW'(out_row_r) + HW'(1)) >= eff_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_slot_r  <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_slot_r <= '0;
      in_ahead_r <= 1'b0;
    end else begin
      // pixel written: step the input position
      if (mem_we) begin
        if (!in_col_wrap) begin
          in_col_r <= in_col_r + CW'(1);
        end else begin
          in_col_r <= '0;
          if (in_row_wrap) begin
            in_row_r   <= '0;
            in_slot_r  <= '0;
            in_ahead_r <= 1'b1;
          end else begin
            in_row_r  <= in_row_r + ROW_W'(1);
            in_slot_r <= (in_slot_r == SW'(STORE_ROWS - 1)) ? '0 : in_slot_r + SW'(1);
          end
        end
      end
      // result delivered: step the output position
      if (emit) begin
        if (!out_col_wrap) begin
          out_col_r <= out_col_r + CW'(1);
        end else begin
          out_col_r <= '0;
          if (out_row_wrap) begin
            out_row_r  <= '0;
            out_slot_r <= '0;
            in_ahead_r <= 1'b0;
          end else begin
            out_row_r  <= out_row_r + ROW_W'(1);
            out_slot_r <= (out_slot_r == SW'(STORE_ROWS - 1)) ? '0 : out_slot_r + SW'(1);
          end
        end
      end
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pixel_r <= result;
      out_last_r  <= out_col_wrap && out_row_wrap;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel      = out_pixel_r;
  assign out_frame_last = out_last_r;

  // ---- assertions ----
  // the line store port belongs to the window walk while sweeping
  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> !mem_we)
    else $error("line store written during window sweep");

  // a pending result is never overwritten
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_valid_r && !out_ready) |=> (state_r == ST_EMIT))
    else $error("result emitted over a pending transaction");

  // the walk stays inside the window
  a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> (dr_r <= rad_s && dc_r <= rad_s))
    else $error("window walk out of range");

endmodule

// ===== src/wbs_line_mem.sv =====
// ----------------------------------------------------------------------------
// wbs_line_mem
// single-port line store, registered read
// ----------------------------------------------------------------------------
module wbs_line_mem #(
  parameter int AW = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

endmodule

// ===== src/wbs_accum.sv =====
// ----------------------------------------------------------------------------
// wbs_accum
// window multiply-accumulate and the mean, gaussian and unsharp post steps
// ----------------------------------------------------------------------------
module wbs_accum #(
  parameter int MAX_RADIUS       = wbs_pkg::WBS_MAX_RADIUS,
  parameter int WEIGHT_FRAC_BITS = wbs_pkg::WBS_WEIGHT_FRAC
) (
  input  logic                      clk,
  input  wbs_pkg::acc_ctl_t         ctl,
  input  wbs_pkg::tap_t             tap,
  input  logic [7:0]                rdata,
  input  logic [1:0]                mode,
  input  logic [1:0]                rad,
  input  logic [wbs_pkg::AMT_W-1:0] amount,
  output logic [7:0]                result
);
  import wbs_pkg::*;

  localparam int SIDE   = 2 * MAX_RADIUS + 1;
  localparam int SUM_W  = $clog2(SIDE * SIDE * PIX_MAX + 1);
  localparam int WSUM_W = SUM_W + WGT_W;
  localparam int MP_W   = SUM_W + RECIP_W;

  logic [7:0]          px;
  logic                s1_vld_r;
  logic                s1_centre_r;
  logic [7:0]          px_r;
  logic [7+WGT_W:0]    prod_r;
  logic [SUM_W-1:0]    sum_r;
  logic [WSUM_W-1:0]   wsum_r;
  logic [7:0]          orig_r;
  logic [WSUM_W-1:0]   wshift;
  logic [7:0]          blur;
  logic [7:0]          blur_r;
  logic [MP_W-1:0]     mean_prod_r;
  logic signed [8:0]   diff_r;
  logic [7:0]          mean_r;
  logic signed [20:0]  sprod_r;
  logic signed [12:0]  q;
  logic signed [13:0]  val;
  logic [7:0]          sharp;

  assign px = tap.inb ? rdata : 8'd0;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      s1_vld_r <= 1'b0;
      sum_r    <= '0;
      wsum_r   <= '0;
      orig_r   <= '0;
    end else begin
      s1_vld_r    <= tap.vld;
      s1_centre_r <= tap.centre;
      px_r        <= px;
      prod_r      <= px * tap.weight;
      if (s1_vld_r) begin
        sum_r  <= sum_r + SUM_W'(px_r);
        wsum_r <= wsum_r + WSUM_W'(prod_r);
        if (s1_centre_r) begin
          orig_r <= px_r;
        end
      end
    end
  end

  // gaussian blur, saturated to a pixel
  assign wshift = wsum_r >> WEIGHT_FRAC_BITS;
  assign blur   = (wshift > WSUM_W'(PIX_MAX)) ? 8'(PIX_MAX) : wshift[7:0];

  always_ff @(posedge clk) begin
    if (ctl.post1) begin
      blur_r      <= blur;
      mean_prod_r <= sum_r * mean_recip(rad);
      diff_r      <= $signed({1'b0, orig_r}) - $signed({1'b0, blur});
    end
    if (ctl.post2) begin
      mean_r  <= 8'(mean_prod_r >> RECIP_SHIFT);
      sprod_r <= diff_r * $signed(amount);
    end
  end

  // truncating divide by 256, then clamp
  always_comb begin
    q = 13'(sprod_r >>> 8);
    if (sprod_r[20] && (sprod_r[7:0] != 8'd0)) begin
      q = q + 13'sd1;
    end
    val = $signed({6'd0, orig_r}) + 14'(q);
    if (val < 0) begin
      sharp = 8'd0;
    end else if (val > 14'sd255) begin
      sharp = 8'(PIX_MAX);
    end else begin
      sharp = val[7:0];
    end
  end

  always_comb begin
    case (mode)
      MODE_GAUSS:   result = blur_r;
      MODE_SHARPEN: result = sharp;
      default:      result = mean_r;
    endcase
  end

endmodule
